// ===== hw/rtl/qck_pkg.sv =====
// Types and constants shared by the quadrant chroma-key compositor.
`default_nettype none
package qck_pkg;

  localparam int unsigned COLOR_W  = 8;
  localparam int unsigned LIMITS_W = 64;
  localparam int unsigned DIM_REG_W = 12;
  localparam int unsigned MODE_W   = 3;
  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 64;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_RED_LIMITS    = 3'd0,
    REG_GREEN_LIMITS  = 3'd1,
    REG_BLUE_LIMITS   = 3'd2,
    REG_FRAME_WIDTH   = 3'd3,
    REG_FRAME_HEIGHT  = 3'd4,
    REG_WINDOW_MODE   = 3'd5,
    REG_WINDOW_WIDTH  = 3'd6,
    REG_WINDOW_HEIGHT = 3'd7
  } cfg_reg_t;

  localparam logic [MODE_W-1:0] MODE_FULL         = 3'd0;
  localparam logic [MODE_W-1:0] MODE_TOP_LEFT     = 3'd1;
  localparam logic [MODE_W-1:0] MODE_BOTTOM_LEFT  = 3'd2;
  localparam logic [MODE_W-1:0] MODE_TOP_RIGHT    = 3'd3;
  localparam logic [MODE_W-1:0] MODE_BOTTOM_RIGHT = 3'd4;

  localparam logic [DIM_REG_W-1:0] FRAME_WIDTH_RST   = 12'd640;
  localparam logic [DIM_REG_W-1:0] FRAME_HEIGHT_RST  = 12'd480;
  localparam logic [DIM_REG_W-1:0] WINDOW_WIDTH_RST  = 12'd320;
  localparam logic [DIM_REG_W-1:0] WINDOW_HEIGHT_RST = 12'd240;
  localparam int unsigned MIN_DIM = 2;

  typedef struct packed {
    logic [COLOR_W-1:0] src_red;
    logic [COLOR_W-1:0] src_green;
    logic [COLOR_W-1:0] src_blue;
    logic [COLOR_W-1:0] bg_red;
    logic [COLOR_W-1:0] bg_green;
    logic [COLOR_W-1:0] bg_blue;
    logic               frame_start;
  } in_item_t;

  typedef struct packed {
    logic [COLOR_W-1:0] out_red;
    logic [COLOR_W-1:0] out_green;
    logic [COLOR_W-1:0] out_blue;
    logic               keyed;
    logic               frame_end;
  } out_item_t;

  function automatic logic in_key_range(input logic [LIMITS_W-1:0] lim, input logic [1:0] q,
                                        input logic [COLOR_W-1:0] v);
    logic [COLOR_W-1:0] lo;
    logic [COLOR_W-1:0] hi;
    lo = lim[{q, 4'd0} +: COLOR_W];
    hi = lim[{q, 4'd8} +: COLOR_W];
    return (v >= lo) && (v <= hi);
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/qck_in_if.sv =====
// Request channel carrying source and background pixel pairs.
`default_nettype none
interface qck_in_if;
  import qck_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/qck_out_if.sv =====
// Request channel carrying composited pixels.
`default_nettype none
interface qck_out_if;
  import qck_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/quadrant_chroma_key_compositor.sv =====
// Top level of the quadrant chroma-key compositor.
// The block takes one source/background pixel pair per clock and returns one composited
// pixel per pair, presented on out_px from the result register. The first register
// stage captures the pixel with its column/row position; the second holds the result
// after the quadrant lookup and the red/green/blue range compare. Throughput is one
// pixel per clock while out_px is not stalled; a stalled output is absorbed by the two
// stages before in_px.ready drops. Configuration is written through
// cfg_we/cfg_addr/cfg_wdata while no pixel is in flight; frame and window sizes are clamped
// to 2..MAX_DIM and to the frame, respectively.
`default_nettype none
module quadrant_chroma_key_compositor #(
  parameter int unsigned MAX_DIM = 2048
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  qck_in_if.sink                              in_px,
  qck_out_if.source                           out_px,
  input  wire logic                           cfg_we,
  input  wire logic [qck_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  wire logic [qck_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import qck_pkg::*;

  localparam int unsigned CNT_W = $clog2(MAX_DIM);
  localparam int unsigned DIM_W = $clog2(MAX_DIM + 1);
  localparam int unsigned CMP_W = (DIM_W > DIM_REG_W) ? DIM_W : DIM_REG_W;

  logic [LIMITS_W-1:0]  red_limits_r;
  logic [LIMITS_W-1:0]  green_limits_r;
  logic [LIMITS_W-1:0]  blue_limits_r;
  logic [DIM_REG_W-1:0] frame_width_r;
  logic [DIM_REG_W-1:0] frame_height_r;
  logic [MODE_W-1:0]    window_mode_r;
  logic [DIM_REG_W-1:0] window_width_r;
  logic [DIM_REG_W-1:0] window_height_r;

  logic [CNT_W-1:0] column_count_r;
  logic [CNT_W-1:0] row_count_r;
  logic [CNT_W-1:0] column_count_nxt;
  logic [CNT_W-1:0] row_count_nxt;

  logic             s1_valid_r;
  in_item_t         s1_item_r;
  logic [CNT_W-1:0] s1_x_r;
  logic [CNT_W-1:0] s1_y_r;
  logic             s1_last_r;
  logic             s1_ready;

  logic      out_valid_r;
  out_item_t out_item_r;
  out_item_t out_item_nxt;

  logic [CMP_W-1:0] fw_c;
  logic [CMP_W-1:0] fh_c;
  logic [CMP_W-1:0] aw_c;
  logic [CMP_W-1:0] ah_c;
  logic [DIM_W-1:0] fw;
  logic [DIM_W-1:0] fh;
  logic [DIM_W-1:0] aw;
  logic [DIM_W-1:0] ah;
  logic [DIM_W-1:0] offx;
  logic [DIM_W-1:0] offy;
  logic [MODE_W-1:0] mode;
  logic             windowed;

  logic             in_fire;
  logic [CNT_W-1:0] x0;
  logic [CNT_W-1:0] y0;
  logic             col_end;
  logic             row_end;

  logic [DIM_W-1:0] x1;
  logic [DIM_W-1:0] y1;
  logic [DIM_W-1:0] lx;
  logic [DIM_W-1:0] ly;
  logic             in_window;
  logic [1:0]       quad;
  logic             keyed;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      red_limits_r    <= '0;
      green_limits_r  <= '0;
      blue_limits_r   <= '0;
      frame_width_r   <= FRAME_WIDTH_RST;
      frame_height_r  <= FRAME_HEIGHT_RST;
      window_mode_r   <= MODE_FULL;
      window_width_r  <= WINDOW_WIDTH_RST;
      window_height_r <= WINDOW_HEIGHT_RST;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_addr))
        REG_RED_LIMITS:    red_limits_r    <= cfg_wdata;
        REG_GREEN_LIMITS:  green_limits_r  <= cfg_wdata;
        REG_BLUE_LIMITS:   blue_limits_r   <= cfg_wdata;
        REG_FRAME_WIDTH:   frame_width_r   <= cfg_wdata[DIM_REG_W-1:0];
        REG_FRAME_HEIGHT:  frame_height_r  <= cfg_wdata[DIM_REG_W-1:0];
        REG_WINDOW_MODE:   window_mode_r   <= cfg_wdata[MODE_W-1:0];
        REG_WINDOW_WIDTH:  window_width_r  <= cfg_wdata[DIM_REG_W-1:0];
        REG_WINDOW_HEIGHT: window_height_r <= cfg_wdata[DIM_REG_W-1:0];
        default: ;
      endcase
    end
  end

  // effective frame and window geometry
  always_comb begin
    fw_c = CMP_W'(frame_width_r);
    if (fw_c < CMP_W'(MIN_DIM)) fw_c = CMP_W'(MIN_DIM);
    if (fw_c > CMP_W'(MAX_DIM)) fw_c = CMP_W'(MAX_DIM);
    fh_c = CMP_W'(frame_height_r);
    if (fh_c < CMP_W'(MIN_DIM)) fh_c = CMP_W'(MIN_DIM);
    if (fh_c > CMP_W'(MAX_DIM)) fh_c = CMP_W'(MAX_DIM);
    fw = DIM_W'(fw_c);
    fh = DIM_W'(fh_c);

    mode = (window_mode_r > MODE_BOTTOM_RIGHT) ? MODE_FULL : window_mode_r;
    windowed = (mode != MODE_FULL);

    aw_c = CMP_W'(window_width_r);
    if (aw_c < CMP_W'(MIN_DIM)) aw_c = CMP_W'(MIN_DIM);
    if (aw_c > fw_c) aw_c = fw_c;
    ah_c = CMP_W'(window_height_r);
    if (ah_c < CMP_W'(MIN_DIM)) ah_c = CMP_W'(MIN_DIM);
    if (ah_c > fh_c) ah_c = fh_c;

    aw   = windowed ? DIM_W'(aw_c) : fw;
    ah   = windowed ? DIM_W'(ah_c) : fh;
    offx = (mode == MODE_TOP_RIGHT || mode == MODE_BOTTOM_RIGHT) ? (fw - aw) : '0;
    offy = (mode == MODE_BOTTOM_LEFT || mode == MODE_BOTTOM_RIGHT) ? (fh - ah) : '0;
  end

  // position counters
  assign s1_ready     = !out_valid_r || out_px.ready;
  assign in_px.ready  = !s1_valid_r || s1_ready;
  assign in_fire      = in_px.valid && in_px.ready;

  always_comb begin
    x0 = in_px.data.frame_start ? '0 : column_count_r;
    y0 = in_px.data.frame_start ? '0 : row_count_r;
    col_end = DIM_W'(x0) >= (fw - DIM_W'(1));
    row_end = DIM_W'(y0) >= (fh - DIM_W'(1));
    column_count_nxt = col_end ? '0 : (x0 + CNT_W'(1));
    row_count_nxt    = col_end ? (row_end ? '0 : (y0 + CNT_W'(1))) : y0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      column_count_r <= '0;
      row_count_r    <= '0;
    end else if (in_fire) begin
      column_count_r <= column_count_nxt;
      row_count_r    <= row_count_nxt;
    end
  end

  // pixel capture stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_px.ready) begin
      s1_valid_r <= in_px.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_item_r <= in_px.data;
      s1_x_r    <= x0;
      s1_y_r    <= y0;
      s1_last_r <= col_end && row_end;
    end
  end

  // quadrant lookup and range compare
  always_comb begin
    x1 = DIM_W'(s1_x_r);
    y1 = DIM_W'(s1_y_r);
    in_window = (x1 >= offx) && (y1 >= offy);
    lx = in_window ? (x1 - offx) : '0;
    ly = in_window ? (y1 - offy) : '0;
    if (windowed && (lx >= aw || ly >= ah)) in_window = 1'b0;
    quad = {ly >= (ah >> 1), lx >= (aw >> 1)};
    keyed = !in_window ||
            (in_key_range(red_limits_r, quad, s1_item_r.src_red) &&
             in_key_range(green_limits_r, quad, s1_item_r.src_green) &&
             in_key_range(blue_limits_r, quad, s1_item_r.src_blue));
    out_item_nxt.out_red   = keyed ? s1_item_r.bg_red : s1_item_r.src_red;
    out_item_nxt.out_green = keyed ? s1_item_r.bg_green : s1_item_r.src_green;
    out_item_nxt.out_blue  = keyed ? s1_item_r.bg_blue : s1_item_r.src_blue;
    out_item_nxt.keyed     = keyed;
    out_item_nxt.frame_end = s1_last_r;
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_ready) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready && s1_valid_r) begin
      out_item_r <= out_item_nxt;
    end
  end

  assign out_px.valid = out_valid_r;
  assign out_px.data  = out_item_r;

endmodule
`default_nettype wire

// ===== dv/tb_top.sv =====
// Self-checking testbench for the quadrant chroma-key compositor with its own pixel predictor.
`default_nettype none
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import qck_pkg::*;

  localparam int unsigned MAX_SIZE     = 2048;
  localparam int unsigned RANDOM_ITEMS = 1800;
  localparam int unsigned CYCLE_LIMIT  = 800000;
  localparam int unsigned DRAIN_LIMIT  = 5000;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_ADDR_W-1:0] cfg_addr;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  qck_in_if  in_px_if ();
  qck_out_if out_px_if ();

  quadrant_chroma_key_compositor #(.MAX_DIM(MAX_SIZE)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_px     (in_px_if),
    .out_px    (out_px_if),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  // predictor copy of the registers and position counters
  logic [LIMITS_W-1:0]  red_lim;
  logic [LIMITS_W-1:0]  green_lim;
  logic [LIMITS_W-1:0]  blue_lim;
  logic [DIM_REG_W-1:0] frame_w_reg;
  logic [DIM_REG_W-1:0] frame_h_reg;
  logic [MODE_W-1:0]    win_mode_reg;
  logic [DIM_REG_W-1:0] win_w_reg;
  logic [DIM_REG_W-1:0] win_h_reg;
  int unsigned col_pos;
  int unsigned row_pos;

  in_item_t  pixel_pairs[$];
  out_item_t predicted_px[$];

  int unsigned burst_left;
  int unsigned gap_left;
  int unsigned burst_max;
  int unsigned gap_max;
  logic [15:0] stall_pattern;

  int unsigned errors;
  int unsigned accepted_px;
  int unsigned keyed_seen;
  int unsigned frame_ends_seen;
  int unsigned settings_run;
  int unsigned cycle_cnt;

  function automatic int unsigned clamp_size(input int unsigned v, input int unsigned hi);
    if (v < MIN_DIM) v = MIN_DIM;
    if (v > hi) v = hi;
    return v;
  endfunction

  function automatic logic color_in_range(input logic [LIMITS_W-1:0] lim, input logic [1:0] quad,
                                          input logic [COLOR_W-1:0] v);
    logic [15:0] pair;
    pair = lim[16*quad +: 16];
    return (v >= pair[7:0]) && (v <= pair[15:8]);
  endfunction

  function automatic out_item_t composite_pixel(input in_item_t px);
    int unsigned fw, fh, aw, ah, offx, offy, x, y, lx, ly;
    logic [MODE_W-1:0] mode;
    logic [1:0] quad;
    logic inwin, hit;
    out_item_t res;
    fw = clamp_size(frame_w_reg, MAX_SIZE);
    fh = clamp_size(frame_h_reg, MAX_SIZE);
    mode = (win_mode_reg > MODE_BOTTOM_RIGHT) ? MODE_FULL : win_mode_reg;
    aw = fw;
    ah = fh;
    offx = 0;
    offy = 0;
    if (px.frame_start) begin
      col_pos = 0;
      row_pos = 0;
    end
    x = col_pos;
    y = row_pos;
    if (mode != MODE_FULL) begin
      aw = clamp_size(win_w_reg, fw);
      ah = clamp_size(win_h_reg, fh);
      if (mode == MODE_TOP_RIGHT || mode == MODE_BOTTOM_RIGHT) offx = fw - aw;
      if (mode == MODE_BOTTOM_LEFT || mode == MODE_BOTTOM_RIGHT) offy = fh - ah;
    end
    inwin = (x >= offx) && (y >= offy);
    lx = inwin ? x - offx : 0;
    ly = inwin ? y - offy : 0;
    if (mode != MODE_FULL && (lx >= aw || ly >= ah)) inwin = 1'b0;
    if (inwin) begin
      quad = {ly >= ah / 2, lx >= aw / 2};
      hit = color_in_range(red_lim, quad, px.src_red) &&
            color_in_range(green_lim, quad, px.src_green) &&
            color_in_range(blue_lim, quad, px.src_blue);
    end else begin
      hit = 1'b1;
    end
    res.out_red   = hit ? px.bg_red : px.src_red;
    res.out_green = hit ? px.bg_green : px.src_green;
    res.out_blue  = hit ? px.bg_blue : px.src_blue;
    res.keyed     = hit;
    res.frame_end = (x >= fw - 1) && (y >= fh - 1);
    if (x >= fw - 1) begin
      col_pos = 0;
      row_pos = (y >= fh - 1) ? 0 : y + 1;
    end else begin
      col_pos = x + 1;
    end
    return res;
  endfunction

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $realtime, name, want, got);
    end
  endfunction

  function automatic in_item_t make_px(input int unsigned sr, input int unsigned sg,
                                       input int unsigned sb, input int unsigned br,
                                       input int unsigned bgc, input int unsigned bb,
                                       input logic fs);
    in_item_t px;
    px.src_red     = COLOR_W'(sr);
    px.src_green   = COLOR_W'(sg);
    px.src_blue    = COLOR_W'(sb);
    px.bg_red      = COLOR_W'(br);
    px.bg_green    = COLOR_W'(bgc);
    px.bg_blue     = COLOR_W'(bb);
    px.frame_start = fs;
    return px;
  endfunction

  function automatic logic [LIMITS_W-1:0] random_limits();
    logic [LIMITS_W-1:0] lim;
    int unsigned lo, hi;
    lim = '0;
    for (int q = 0; q < 4; q++) begin
      case ($urandom_range(0, 4))
        0: begin lo = 0; hi = 255; end
        1: begin lo = $urandom_range(0, 255); hi = $urandom_range(lo, 255); end
        2: begin lo = $urandom_range(1, 255); hi = $urandom_range(0, lo - 1); end
        3: begin
          lo = $urandom_range(0, 255);
          hi = lo + $urandom_range(0, 16);
          if (hi > 255) hi = 255;
        end
        default: begin lo = $urandom_range(0, 255); hi = $urandom_range(0, 255); end
      endcase
      lim[16*q +: 16] = {hi[7:0], lo[7:0]};
    end
    return lim;
  endfunction

  function automatic int unsigned pick_channel(input logic [LIMITS_W-1:0] lim,
                                               input int unsigned quad);
    logic [15:0] pair;
    pair = lim[16*quad +: 16];
    if (pair[7:0] <= pair[15:8]) return $urandom_range(pair[7:0], pair[15:8]);
    return $urandom_range(0, 255);
  endfunction

  // bias half of the source colors into one quadrant's key range
  function automatic in_item_t random_px(input logic fs);
    int unsigned quad;
    in_item_t px;
    px = make_px($urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255),
                 $urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255), fs);
    if ($urandom_range(0, 1)) begin
      quad = $urandom_range(0, 3);
      px.src_red   = COLOR_W'(pick_channel(red_lim, quad));
      px.src_green = COLOR_W'(pick_channel(green_lim, quad));
      px.src_blue  = COLOR_W'(pick_channel(blue_lim, quad));
    end
    return px;
  endfunction

  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    case (idx)
      REG_RED_LIMITS:    red_lim = val;
      REG_GREEN_LIMITS:  green_lim = val;
      REG_BLUE_LIMITS:   blue_lim = val;
      REG_FRAME_WIDTH:   frame_w_reg = val[DIM_REG_W-1:0];
      REG_FRAME_HEIGHT:  frame_h_reg = val[DIM_REG_W-1:0];
      REG_WINDOW_MODE:   win_mode_reg = val[MODE_W-1:0];
      REG_WINDOW_WIDTH:  win_w_reg = val[DIM_REG_W-1:0];
      REG_WINDOW_HEIGHT: win_h_reg = val[DIM_REG_W-1:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // sample between edges so a request popped at this edge is already visible as valid
  task automatic wait_idle();
    while (pixel_pairs.size() != 0 || in_px_if.valid || predicted_px.size() != 0)
      @(negedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic int unsigned random_size();
    case ($urandom_range(0, 19))
      0: return $urandom_range(0, 1);
      1: return MAX_SIZE;
      2: return $urandom_range(MAX_SIZE + 1, 4095);
      3: return MIN_DIM;
      default: return $urandom_range(2, 12);
    endcase
  endfunction

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // sender: bursts of random length separated by random gaps
  always @(posedge clk) begin
    if (!rst_n) begin
      in_px_if.valid <= 1'b0;
      in_px_if.data  <= '0;
    end else begin
      if (in_px_if.valid && in_px_if.ready) begin
        predicted_px.push_back(composite_pixel(in_px_if.data));
        accepted_px++;
      end
      if (!in_px_if.valid || in_px_if.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_px_if.valid <= 1'b0;
        end else if (pixel_pairs.size() > 0) begin
          in_px_if.valid <= 1'b1;
          in_px_if.data  <= pixel_pairs.pop_front();
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, burst_max);
            gap_left   = (gap_max == 0) ? 0 : $urandom_range(1, gap_max);
          end else begin
            burst_left--;
          end
        end else begin
          in_px_if.valid <= 1'b0;
        end
      end
    end
  end

  // receiver: stall on a rotating pattern, check each composited pixel
  always @(posedge clk) begin : result_check
    out_item_t want;
    out_item_t got;
    if (!rst_n) begin
      out_px_if.ready <= 1'b0;
    end else begin
      if (out_px_if.valid && out_px_if.ready) begin
        got = out_px_if.data;
        if (predicted_px.size() == 0) begin
          errors++;
          $display("%0t: unexpected pixel, expected none, actual %h", $realtime, got);
        end else begin
          want = predicted_px.pop_front();
          check_field("out_red", want.out_red, got.out_red);
          check_field("out_green", want.out_green, got.out_green);
          check_field("out_blue", want.out_blue, got.out_blue);
          check_field("keyed", want.keyed, got.keyed);
          check_field("frame_end", want.frame_end, got.frame_end);
          keyed_seen += want.keyed;
          frame_ends_seen += want.frame_end;
        end
      end
      stall_pattern = {stall_pattern[0], stall_pattern[15:1]};
      out_px_if.ready <= stall_pattern[0];
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    int unsigned random_sent, n_items, frame_px, fw_val, fh_val, drain;
    logic fresh, noisy, fs;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_addr = '0;
    cfg_wdata = '0;
    in_px_if.valid = 1'b0;
    in_px_if.data = '0;
    out_px_if.ready = 1'b0;
    red_lim = '0;
    green_lim = '0;
    blue_lim = '0;
    frame_w_reg = FRAME_WIDTH_RST;
    frame_h_reg = FRAME_HEIGHT_RST;
    win_mode_reg = MODE_FULL;
    win_w_reg = WINDOW_WIDTH_RST;
    win_h_reg = WINDOW_HEIGHT_RST;
    col_pos = 0;
    row_pos = 0;
    burst_left = 0;
    gap_left = 0;
    burst_max = 8;
    gap_max = 3;
    stall_pattern = 16'hB6DB;
    errors = 0;
    accepted_px = 0;
    keyed_seen = 0;
    frame_ends_seen = 0;
    settings_run = 1;
    cycle_cnt = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // reset limits key only black sources
    pixel_pairs.push_back(make_px(0, 0, 0, 255, 255, 255, 1'b1));
    pixel_pairs.push_back(make_px(255, 255, 255, 0, 0, 0, 1'b0));
    wait_idle();

    // 2x2 frame, one quadrant per pixel, inverted limits in the top right
    write_reg(REG_RED_LIMITS, 64'hFFFF_140A_64C8_FF00);
    write_reg(REG_GREEN_LIMITS, 64'hFF00_FF00_FF00_FF00);
    write_reg(REG_BLUE_LIMITS, 64'hFF00_FF00_FF00_FF00);
    write_reg(REG_FRAME_WIDTH, 64'd2);
    write_reg(REG_FRAME_HEIGHT, 64'd2);
    settings_run++;
    pixel_pairs.push_back(make_px(5, 0, 255, 1, 2, 3, 1'b1));
    pixel_pairs.push_back(make_px(150, 9, 9, 4, 5, 6, 1'b0));
    pixel_pairs.push_back(make_px(15, 255, 0, 7, 8, 9, 1'b0));
    pixel_pairs.push_back(make_px(255, 128, 128, 255, 0, 255, 1'b0));
    pixel_pairs.push_back(make_px(255, 0, 0, 10, 11, 12, 1'b1));
    pixel_pairs.push_back(make_px(100, 0, 0, 13, 14, 15, 1'b0));
    pixel_pairs.push_back(make_px(21, 0, 0, 16, 17, 18, 1'b0));
    pixel_pairs.push_back(make_px(254, 0, 0, 19, 20, 21, 1'b0));
    wait_idle();

    // frame sizes below and above range, unknown window mode
    write_reg(REG_FRAME_WIDTH, 64'd0);
    write_reg(REG_FRAME_HEIGHT, 64'd4095);
    write_reg(REG_WINDOW_MODE, 64'd7);
    settings_run++;
    pixel_pairs.push_back(make_px(200, 1, 2, 30, 31, 32, 1'b1));
    pixel_pairs.push_back(make_px(3, 4, 5, 33, 34, 35, 1'b0));
    wait_idle();

    // bottom right window with window sizes out of range
    write_reg(REG_FRAME_WIDTH, 64'd4);
    write_reg(REG_FRAME_HEIGHT, 64'd4);
    write_reg(REG_WINDOW_MODE, MODE_BOTTOM_RIGHT);
    write_reg(REG_WINDOW_WIDTH, 64'd0);
    write_reg(REG_WINDOW_HEIGHT, 64'd4095);
    settings_run++;
    for (int i = 0; i < 4; i++) pixel_pairs.push_back(make_px(7, 7, 7, 40, 41, 42, i == 0));
    wait_idle();

    // shrink the frame while the column counter sits past the new edge
    write_reg(REG_WINDOW_MODE, MODE_FULL);
    write_reg(REG_FRAME_WIDTH, 64'd8);
    write_reg(REG_FRAME_HEIGHT, 64'd8);
    for (int i = 0; i < 4; i++) pixel_pairs.push_back(make_px(9, 9, 9, 50, 51, 52, i == 0));
    wait_idle();
    write_reg(REG_FRAME_WIDTH, 64'd2);
    write_reg(REG_FRAME_HEIGHT, 64'd2);
    settings_run += 2;
    for (int i = 0; i < 3; i++) pixel_pairs.push_back(make_px(60, 61, 62, 63, 64, 65, 1'b0));
    wait_idle();

    random_sent = 0;
    while (random_sent < RANDOM_ITEMS) begin
      wait_idle();
      fw_val = random_size();
      fh_val = random_size();
      write_reg(REG_RED_LIMITS, random_limits());
      write_reg(REG_GREEN_LIMITS, random_limits());
      write_reg(REG_BLUE_LIMITS, random_limits());
      write_reg(REG_FRAME_WIDTH, fw_val);
      write_reg(REG_FRAME_HEIGHT, fh_val);
      write_reg(REG_WINDOW_MODE, $urandom_range(0, 7));
      write_reg(REG_WINDOW_WIDTH, ($urandom_range(0, 9) == 0) ? 4095 :
                $urandom_range(0, clamp_size(fw_val, MAX_SIZE) + 2));
      write_reg(REG_WINDOW_HEIGHT, ($urandom_range(0, 9) == 0) ? 4095 :
                $urandom_range(0, clamp_size(fh_val, MAX_SIZE) + 2));
      settings_run++;

      case ($urandom_range(0, 3))
        0: gap_max = 0;
        1: gap_max = 1;
        default: gap_max = $urandom_range(2, 6);
      endcase
      burst_max = $urandom_range(1, 16);
      case ($urandom_range(0, 3))
        0: stall_pattern = 16'hFFFF;
        1: stall_pattern = 16'h0001 << $urandom_range(0, 15);
        default: stall_pattern = 16'($urandom_range(1, 16'hFFFF));
      endcase

      frame_px = clamp_size(fw_val, MAX_SIZE) * clamp_size(fh_val, MAX_SIZE);
      n_items = frame_px * $urandom_range(1, 3);
      if (n_items > 160) n_items = $urandom_range(40, 160);
      noisy = ($urandom_range(0, 7) == 0);
      fresh = ($urandom_range(0, 3) != 0);
      for (int i = 0; i < n_items; i++) begin
        if (settings_run % 5 == 0 && i == n_items / 2) wait_idle();
        if (noisy) fs = ($urandom_range(0, 7) == 0);
        else fs = fresh && (i % frame_px == 0);
        pixel_pairs.push_back(random_px(fs));
      end
      random_sent += n_items;
    end

    while (pixel_pairs.size() != 0 || in_px_if.valid) @(negedge clk);
    drain = 0;
    while (predicted_px.size() != 0 && drain < DRAIN_LIMIT) begin
      @(posedge clk);
      drain++;
    end
    repeat (8) @(posedge clk);
    if (predicted_px.size() != 0) begin
      errors++;
      $display("%0t: %0d pixels never came out, expected %h, actual none",
               $realtime, predicted_px.size(), predicted_px[0]);
    end
    $display("Composited %0d pixel pairs over %0d register settings.",
             accepted_px, settings_run);
    $display("Background chosen %0d times, %0d frame ends seen, %0d errors.",
             keyed_seen, frame_ends_seen, errors);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire
